[hw/rtl/rob_pkg.sv]
package rob_pkg;

	// Field widths of one word on each channel and of the count register.
	localparam int ID_W    = 16;
	localparam int VALUE_W = 32;
	localparam int COUNT_W = 17;

	typedef logic [ID_W-1:0]    id_t;
	typedef logic [VALUE_W-1:0] value_t;
	typedef logic [COUNT_W-1:0] count_t;

	// Outcome of checking a captured id against the window.
	typedef enum logic [1:0] {
		CLS_REJECT,
		CLS_PARK,
		CLS_DIRECT
	} class_t;

	// Source of the word loaded into the output register.
	typedef enum logic [1:0] {
		EMIT_NONE,
		EMIT_DROP,
		EMIT_DIRECT,
		EMIT_DRAIN
	} emit_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic  capture;
		logic  park;
		emit_t emit;
	} rob_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		class_t cls;
		logic   more;
		logic   out_free;
	} rob_status_t;

endpackage

[hw/rtl/rob_in_if.sv]
interface rob_in_if;
	import rob_pkg::*;

	logic   valid;
	logic   ready;
	id_t    item_id;
	value_t item_value;

	modport source (output valid, output item_id, output item_value, input ready);
	modport sink   (input valid, input item_id, input item_value, output ready);

endinterface

[hw/rtl/rob_out_if.sv]
interface rob_out_if;
	import rob_pkg::*;

	logic   valid;
	logic   ready;
	id_t    out_id;
	value_t out_value;
	logic   run_last;
	logic   dropped;
	logic   all_done;

	modport source (
		output valid, output out_id, output out_value,
		output run_last, output dropped, output all_done,
		input ready
	);
	modport sink (
		input valid, input out_id, input out_value,
		input run_last, input dropped, input all_done,
		output ready
	);

endinterface

[hw/rtl/rob_ctrl.sv]
module rob_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  rob_pkg::rob_status_t sts,
	output rob_pkg::rob_cmd_t    cmd
);
	import rob_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CLASSIFY,
		ST_DRAIN
	} state_t;

	state_t state_q;
	logic   ready_q;
	logic   accept;

	assign in_ready = ready_q;
	assign accept   = in_valid && ready_q;

	// Commands follow from the state and the datapath status.
	always_comb begin
		cmd.capture = 1'b0;
		cmd.park    = 1'b0;
		cmd.emit    = EMIT_NONE;
		case (state_q)
			ST_IDLE: begin
				cmd.capture = accept;
			end
			ST_CLASSIFY: begin
				case (sts.cls)
					CLS_REJECT: begin
						if (sts.out_free) cmd.emit = EMIT_DROP;
					end
					CLS_PARK: begin
						cmd.park = 1'b1;
					end
					CLS_DIRECT: begin
						if (sts.out_free) cmd.emit = EMIT_DIRECT;
					end
					default: begin
						cmd.park = 1'b0;
					end
				endcase
			end
			ST_DRAIN: begin
				if (sts.out_free) cmd.emit = EMIT_DRAIN;
			end
			default: begin
				cmd.capture = 1'b0;
			end
		endcase
	end

	// State register and the registered ready.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ready_q <= 1'b1;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_CLASSIFY;
						ready_q <= 1'b0;
					end
				end
				ST_CLASSIFY: begin
					case (sts.cls)
						CLS_PARK: begin
							state_q <= ST_IDLE;
							ready_q <= 1'b1;
						end
						CLS_DIRECT: begin
							if (sts.out_free) begin
								if (sts.more) begin
									state_q <= ST_DRAIN;
								end else begin
									state_q <= ST_IDLE;
									ready_q <= 1'b1;
								end
							end
						end
						default: begin
							if (sts.out_free) begin
								state_q <= ST_IDLE;
								ready_q <= 1'b1;
							end
						end
					endcase
				end
				ST_DRAIN: begin
					if (sts.out_free && !sts.more) begin
						state_q <= ST_IDLE;
						ready_q <= 1'b1;
					end
				end
				default: begin
					state_q <= ST_IDLE;
					ready_q <= 1'b1;
				end
			endcase
		end
	end

endmodule

[hw/rtl/rob_dpath.sv]
module rob_dpath #(
	parameter int WINDOW_DEPTH = 64
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  rob_pkg::count_t      cfg_wdata,
	input  rob_pkg::id_t         in_id,
	input  rob_pkg::value_t      in_value,
	input  logic                 out_ready,
	output logic                 out_valid,
	output rob_pkg::id_t         out_id,
	output rob_pkg::value_t      out_value,
	output logic                 out_last,
	output logic                 out_dropped,
	output logic                 out_done,
	input  rob_pkg::rob_cmd_t    cmd,
	output rob_pkg::rob_status_t sts
);
	import rob_pkg::*;

	localparam int SLOT_W = $clog2(WINDOW_DEPTH);
	localparam logic [SLOT_W:0]   DEPTH_X   = (SLOT_W+1)'(WINDOW_DEPTH);
	localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(WINDOW_DEPTH - 1);
	localparam count_t            DEPTH_C   = COUNT_W'(WINDOW_DEPTH);

	count_t                   count_q;
	count_t                   next_exp_q;
	logic [SLOT_W-1:0]        next_slot_q;
	logic [WINDOW_DEPTH-1:0]  valid_q;
	value_t                   held_mem [WINDOW_DEPTH];
	value_t                   rd_data_q;
	id_t                      id_q;
	value_t                   value_q;

	logic                     out_valid_q;
	id_t                      out_id_q;
	value_t                   out_value_q;
	logic                     out_last_q;
	logic                     out_dropped_q;
	logic                     out_done_q;

	count_t                   id_ext;
	count_t                   diff;
	count_t                   next_exp_inc;
	logic                     in_window;
	logic [SLOT_W:0]          slot_sum;
	logic [SLOT_W-1:0]        park_slot;
	logic [SLOT_W-1:0]        slot_inc;
	logic                     more;
	logic                     emit_run;

	// Window check on the captured id and its slot, by compares and subtracts.
	assign id_ext    = {1'b0, id_q};
	assign diff      = id_ext - next_exp_q;
	assign in_window = (id_ext >= next_exp_q) && (diff < DEPTH_C) && (id_ext < count_q);
	assign slot_sum  = {1'b0, next_slot_q} + {1'b0, diff[SLOT_W-1:0]};
	assign park_slot = (slot_sum >= DEPTH_X) ? SLOT_W'(slot_sum - DEPTH_X)
	                                         : slot_sum[SLOT_W-1:0];

	// Slot after the expected one and whether the run goes on past it.
	assign slot_inc     = (next_slot_q == LAST_SLOT) ? '0 : next_slot_q + SLOT_W'(1);
	assign next_exp_inc = next_exp_q + COUNT_W'(1);
	assign more         = valid_q[slot_inc] && (next_exp_inc < count_q);
	assign emit_run     = (cmd.emit == EMIT_DIRECT) || (cmd.emit == EMIT_DRAIN);

	// Status back to the controller.
	always_comb begin
		if (!in_window) begin
			sts.cls = CLS_REJECT;
		end else if (id_ext == next_exp_q) begin
			sts.cls = CLS_DIRECT;
		end else begin
			sts.cls = CLS_PARK;
		end
		sts.more     = more;
		sts.out_free = !out_valid_q || out_ready;
	end

	// Captured input word.
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			id_q    <= in_id;
			value_q <= in_value;
		end
	end

	// Count register, expected id, its slot and the valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			next_exp_q  <= '0;
			next_slot_q <= '0;
			valid_q     <= '0;
		end else begin
			if (cfg_we) count_q <= cfg_wdata;
			if (cmd.park) valid_q[park_slot] <= 1'b1;
			if (emit_run) begin
				valid_q[next_slot_q] <= 1'b0;
				next_exp_q           <= next_exp_inc;
				next_slot_q          <= slot_inc;
			end
		end
	end

	// Held-value store: one write port for parking, one registered read for draining.
	always_ff @(posedge clk) begin
		if (cmd.park) held_mem[park_slot] <= value_q;
		if (emit_run && more) rd_data_q <= held_mem[slot_inc];
	end

	// Output register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit != EMIT_NONE) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		case (cmd.emit)
			EMIT_DROP: begin
				out_id_q      <= id_q;
				out_value_q   <= '0;
				out_last_q    <= 1'b1;
				out_dropped_q <= 1'b1;
				out_done_q    <= (next_exp_q >= count_q);
			end
			EMIT_DIRECT: begin
				out_id_q      <= id_q;
				out_value_q   <= value_q;
				out_last_q    <= !more;
				out_dropped_q <= 1'b0;
				out_done_q    <= (next_exp_inc >= count_q);
			end
			EMIT_DRAIN: begin
				out_id_q      <= next_exp_q[ID_W-1:0];
				out_value_q   <= rd_data_q;
				out_last_q    <= !more;
				out_dropped_q <= 1'b0;
				out_done_q    <= (next_exp_inc >= count_q);
			end
			default: begin
				out_id_q <= out_id_q;
			end
		endcase
	end

	assign out_valid   = out_valid_q;
	assign out_id      = out_id_q;
	assign out_value   = out_value_q;
	assign out_last    = out_last_q;
	assign out_dropped = out_dropped_q;
	assign out_done    = out_done_q;

endmodule

[hw/rtl/in_order_reorder_buffer.sv]
// A word is captured into the input register when it is accepted, checked against the window in
// the classify state, and loaded into the output register once that register is free.
// An input is parked, dropped or released with the run that it completes; the held-value store
// drains that run one word per cycle while the output is not stalled, through its single
// registered read port. The next input is taken only after the last word is loaded.
// Reset (arst_n low) clears the expected id, the count register and all valid bits at
// once; the held values themselves are not cleared.
module in_order_reorder_buffer #(
	parameter int WINDOW_DEPTH = 64
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cfg_we,
	input  rob_pkg::count_t cfg_wdata,
	rob_in_if.sink          items,
	rob_out_if.source       results
);
	import rob_pkg::*;

	rob_cmd_t    cmd;
	rob_status_t sts;

	// Sequencing of capture, check, park and drain.
	rob_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (items.valid),
		.in_ready (items.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// Window check, held store and output register.
	rob_dpath #(
		.WINDOW_DEPTH (WINDOW_DEPTH)
	) u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.in_id       (items.item_id),
		.in_value    (items.item_value),
		.out_ready   (results.ready),
		.out_valid   (results.valid),
		.out_id      (results.out_id),
		.out_value   (results.out_value),
		.out_last    (results.run_last),
		.out_dropped (results.dropped),
		.out_done    (results.all_done),
		.cmd         (cmd),
		.sts         (sts)
	);

endmodule

[hw/rtl/rob_checker.sv]
module rob_checker (
	input logic            clk,
	input logic            arst_n,
	input logic            in_valid,
	input logic            in_ready,
	input logic            out_valid,
	input logic            out_ready,
	input rob_pkg::id_t    out_id,
	input rob_pkg::value_t out_value,
	input logic            run_last,
	input logic            dropped
);

	// A stalled result word keeps its id and value.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_id) && $stable(out_value))
		else $error("result word changed while stalled");

	// A dropped input closes its own run.
	a_drop_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && dropped |-> run_last)
		else $error("dropped word without run_last");

	// No new input is taken while a run is still being delivered.
	a_run_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !run_last |-> !in_ready)
		else $error("input ready in the middle of a run");

	// Once a non-final word of a run is taken, the next one follows at once.
	a_run_continues: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !run_last |=> out_valid)
		else $error("run broke off before its last word");

	// Only one input is in flight at a time.
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken on consecutive cycles");

endmodule

bind in_order_reorder_buffer rob_checker u_rob_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (items.valid),
	.in_ready  (items.ready),
	.out_valid (results.valid),
	.out_ready (results.ready),
	.out_id    (results.out_id),
	.out_value (results.out_value),
	.run_last  (results.run_last),
	.dropped   (results.dropped)
);
